// File: rtl/wpts_pkg.sv
// Package for the WAV PCM to 16-bit stereo converter.
// Holds the parse phase type, chunk constants and the structs passed between modules.
// No dependencies.
package wpts_pkg;

    typedef enum logic [2:0] {
        PH_RIFF      = 3'd0,
        PH_FMT_HDR   = 3'd1,
        PH_FMT_SKIP  = 3'd2,
        PH_FMT_BODY  = 3'd3,
        PH_DATA_HDR  = 3'd4,
        PH_DATA_SKIP = 3'd5,
        PH_STREAM    = 3'd6
    } phase_t;

    localparam logic [31:0] RIFF_HEADER_BYTES = 32'd12;
    localparam logic [31:0] CHUNK_HDR_BYTES   = 32'd8;
    localparam logic [31:0] FMT_BODY_BYTES    = 32'd16;
    localparam logic [31:0] MAX_RATE          = 32'd48000;
    localparam logic [31:0] ID_FMT            = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA           = 32'h6174_6164;
    localparam logic [7:0]  OFFSET_BIN_FLIP   = 8'h80;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;

    localparam int TDATA_W = 72;

    typedef struct packed {
        logic       clear;
        logic       take;
        logic [7:0] data;
        logic [1:0] nbytes;
        logic       stereo;
    } strm_t;

    typedef struct packed {
        logic        valid;
        logic        accepted;
        logic [31:0] size;
    } report_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } frame_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] left;
        logic [15:0] right;
        logic        accepted;
        logic [31:0] size;
    } result_t;

endpackage

// File: rtl/wpts_parser.sv
// Byte-serial RIFF/WAV chunk parser: header skip, fmt latch and data chunk search.
// Produces the format report and hands sample bytes to the converter.
// Depends on wpts_pkg.
module wpts_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       data,
    input  logic             sof,
    output wpts_pkg::strm_t   strm,
    output wpts_pkg::report_t report
);
    import wpts_pkg::*;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [31:0] count_reg, count_next, count_cur, count_inc, count_dec;
    logic [63:0] hdr_reg, hdr_next, hdr_cur, hdr_shift;
    logic [15:0] chan_reg, chan_next, chan_cur;
    logic [31:0] rate_reg, rate_next, rate_cur;
    logic [15:0] width_reg, width_next, width_cur;
    logic        acc_reg, acc_next, acc_cur;
    logic        verdict;
    logic [31:0] fmt_size;

    // A start-of-file request clears everything before its byte is parsed.
    always_comb
    begin
        phase_cur = sof ? PH_RIFF : phase_reg;
        count_cur = sof ? 32'd0 : count_reg;
        hdr_cur   = sof ? 64'd0 : hdr_reg;
        chan_cur  = sof ? 16'd0 : chan_reg;
        rate_cur  = sof ? 32'd0 : rate_reg;
        width_cur = sof ? 16'd0 : width_reg;
        acc_cur   = sof ? 1'b0 : acc_reg;
    end

    assign count_inc = count_cur + 32'd1;
    assign count_dec = count_cur - 32'd1;
    assign hdr_shift = {data, hdr_cur[63:8]};
    assign fmt_size  = hdr_cur[63:32];
    assign verdict   = (rate_cur <= MAX_RATE) && (chan_cur <= 16'd2)
                       && ((width_cur == 16'd8) || (width_cur == 16'd16)
                           || (width_cur == 16'd24));

    always_comb
    begin
        phase_next = phase_cur;
        count_next = count_cur;
        hdr_next   = hdr_cur;
        chan_next  = chan_cur;
        rate_next  = rate_cur;
        width_next = width_cur;
        acc_next   = acc_cur;
        case (phase_cur)
            PH_RIFF:
            begin
                count_next = count_inc;
                if (count_inc >= RIFF_HEADER_BYTES)
                begin
                    count_next = 32'd0;
                    phase_next = PH_FMT_HDR;
                end
            end
            PH_FMT_HDR, PH_DATA_HDR:
            begin
                hdr_next   = hdr_shift;
                count_next = count_inc;
                if (count_inc >= CHUNK_HDR_BYTES)
                begin
                    count_next = 32'd0;
                    if (phase_cur == PH_FMT_HDR && hdr_shift[31:0] == ID_FMT)
                    begin
                        phase_next = PH_FMT_BODY;
                    end
                    else if (phase_cur == PH_DATA_HDR && hdr_shift[31:0] == ID_DATA)
                    begin
                        acc_next   = verdict;
                        phase_next = PH_STREAM;
                    end
                    else if (hdr_shift[63:32] != 32'd0)
                    begin
                        count_next = hdr_shift[63:32];
                        phase_next = (phase_cur == PH_FMT_HDR) ? PH_FMT_SKIP
                                                               : PH_DATA_SKIP;
                    end
                end
            end
            PH_FMT_SKIP, PH_DATA_SKIP:
            begin
                count_next = count_dec;
                if (count_dec == 32'd0)
                begin
                    phase_next = (phase_cur == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
                end
            end
            PH_FMT_BODY:
            begin
                case (count_cur[3:0])
                    4'd2:    chan_next  = {chan_cur[15:8], data};
                    4'd3:    chan_next  = {data, chan_cur[7:0]};
                    4'd4:    rate_next  = {rate_cur[31:8], data};
                    4'd5:    rate_next  = {rate_cur[31:16], data, rate_cur[7:0]};
                    4'd6:    rate_next  = {rate_cur[31:24], data, rate_cur[15:0]};
                    4'd7:    rate_next  = {data, rate_cur[23:0]};
                    4'd14:   width_next = {width_cur[15:8], data};
                    4'd15:   width_next = {data, width_cur[7:0]};
                    default: ;
                endcase
                count_next = count_inc;
                if (count_inc >= FMT_BODY_BYTES)
                begin
                    if (fmt_size > FMT_BODY_BYTES)
                    begin
                        count_next = fmt_size - FMT_BODY_BYTES;
                        phase_next = PH_DATA_SKIP;
                    end
                    else
                    begin
                        count_next = 32'd0;
                        phase_next = PH_DATA_HDR;
                    end
                end
            end
            PH_STREAM:
            begin
            end
            default:
            begin
                phase_next = PH_RIFF;
            end
        endcase
    end

    always_comb
    begin
        report          = '0;
        strm            = '0;
        strm.data       = data;
        strm.nbytes     = width_cur[4:3];
        strm.stereo     = (chan_cur == 16'd2);
        strm.clear      = take && sof;
        case (phase_cur)
            PH_DATA_HDR:
            begin
                if (take && count_inc >= CHUNK_HDR_BYTES && hdr_shift[31:0] == ID_DATA)
                begin
                    report.valid    = 1'b1;
                    report.accepted = verdict;
                    report.size     = hdr_shift[63:32];
                    strm.clear      = 1'b1;
                end
            end
            PH_STREAM:
            begin
                strm.take = take && acc_cur && (width_cur[15:5] == 11'd0)
                            && (width_cur[4:3] != 2'd0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            count_reg <= '0;
            hdr_reg   <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            width_reg <= '0;
            acc_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            hdr_reg   <= hdr_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            width_reg <= width_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// File: rtl/wpts_sample.sv
// Sample assembler: builds 8, 16 or 24-bit PCM samples from bytes and forms
// 16-bit stereo frames, duplicating mono. Depends on wpts_pkg.
module wpts_sample (
    input  logic            clk,
    input  logic            rst_n,
    input  wpts_pkg::strm_t  strm,
    output wpts_pkg::frame_t frame
);
    import wpts_pkg::*;

    logic [23:0] asm_reg, asm_next, asm_new;
    logic [1:0]  pos_reg, pos_next, pos_inc;
    logic [15:0] left_reg, left_next;
    logic        tog_reg, tog_next;
    logic [15:0] val;
    logic        done;

    always_comb
    begin
        case (pos_reg)
            2'd0:    asm_new = {asm_reg[23:8], strm.data};
            2'd1:    asm_new = {asm_reg[23:16], strm.data, asm_reg[7:0]};
            2'd2:    asm_new = {strm.data, asm_reg[15:0]};
            default: asm_new = asm_reg;
        endcase
    end

    assign pos_inc = pos_reg + 2'd1;
    assign done    = (pos_inc == strm.nbytes);

    always_comb
    begin
        case (strm.nbytes)
            2'd1:    val = {asm_new[7:0] ^ OFFSET_BIN_FLIP, 8'h00};
            2'd2:    val = asm_new[15:0];
            2'd3:    val = asm_new[23:8];
            default: val = 16'd0;
        endcase
    end

    always_comb
    begin
        asm_next    = asm_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        tog_next    = tog_reg;
        frame       = '0;
        if (strm.clear)
        begin
            asm_next = '0;
            pos_next = '0;
            tog_next = 1'b0;
        end
        else if (strm.take)
        begin
            asm_next = asm_new;
            pos_next = pos_inc;
            if (done)
            begin
                asm_next = '0;
                pos_next = '0;
                if (!strm.stereo)
                begin
                    frame.valid = 1'b1;
                    frame.left  = val;
                    frame.right = val;
                end
                else if (!tog_reg)
                begin
                    left_next = val;
                    tog_next  = 1'b1;
                end
                else
                begin
                    tog_next    = 1'b0;
                    frame.valid = 1'b1;
                    frame.left  = left_reg;
                    frame.right = val;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_reg  <= '0;
            pos_reg  <= '0;
            left_reg <= '0;
            tog_reg  <= 1'b0;
        end
        else
        begin
            asm_reg  <= asm_next;
            pos_reg  <= pos_next;
            left_reg <= left_next;
            tog_reg  <= tog_next;
        end
    end

endmodule

// File: rtl/wpts_out_buf.sv
// Result register with one skid entry between the converter and the output stream.
// Depends on wpts_pkg.
module wpts_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  wpts_pkg::result_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output wpts_pkg::result_t out_data
);
    import wpts_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry is full while the result register is empty.");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> in_ready)
        else $error("A result arrived while the skid entry was full.");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> !skid_valid_reg && out_valid_reg
                                  && out_data_reg == $past(skid_data_reg))
        else $error("Skid entry did not move into the result register.");
`endif

endmodule

// File: rtl/wav_pcm_to_stereo16_top.sv
// Top level of the WAV PCM to 16-bit stereo converter.
// Depends on wpts_pkg, wpts_parser, wpts_sample and wpts_out_buf.
//
// Usage:
//   The input stream carries one byte of a WAV file per request on s_tdata;
//   s_tuser high marks the first byte of a new file and restarts the parser.
//   The output stream carries at most one result per input byte. m_tuser low
//   is the format report given when the data chunk is found (data size and
//   format verdict); m_tuser high is a 16-bit stereo frame.
//   A result is registered in the output stage when the byte that caused it is
//   accepted. Throughput: one byte per cycle while s_tready is high, set by the
//   combinational parser and sample assembler between the state registers.
//   When the receiver stalls, the result register holds and one more result
//   goes into a skid entry; s_tready drops only while that entry is full.
//   Reset clears the parser to the start of the RIFF header and empties the
//   output stage; a new file may also start at any time with s_tuser.
module wav_pcm_to_stereo16_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [15:0] left_sample, [31:16] right_sample,
                                   // [32] format_accepted, [64:33] data_bytes,
                                   // [71:65] zero
    output logic        m_tuser    // [0] kind
);
    import wpts_pkg::*;

    logic    take;
    strm_t   strm;
    report_t report;
    frame_t  frame;
    result_t res;
    result_t out_res;

    assign take = s_tvalid && s_tready;

    wpts_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .data   (s_tdata),
        .sof    (s_tuser),
        .strm   (strm),
        .report (report)
    );

    wpts_sample u_sample (
        .clk   (clk),
        .rst_n (rst_n),
        .strm  (strm),
        .frame (frame)
    );

    always_comb
    begin
        if (frame.valid)
        begin
            res.kind     = KIND_FRAME;
            res.left     = frame.left;
            res.right    = frame.right;
            res.accepted = 1'b1;
            res.size     = 32'd0;
        end
        else
        begin
            res.kind     = KIND_REPORT;
            res.left     = 16'd0;
            res.right    = 16'd0;
            res.accepted = report.accepted;
            res.size     = report.size;
        end
    end

    wpts_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame.valid || report.valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {7'd0, out_res.size, out_res.accepted, out_res.right, out_res.left};

endmodule
